// File: design/wpbd_pkg.sv
// Shared types and constants for the windowed price breakout detector.
`default_nettype none

package wpbd_pkg;

	localparam int TIME_W   = 48;
	localparam int PRICE_W  = 24;
	localparam int WINDOW_W = 16;

	localparam int RING_DEPTH_DEFAULT = 1024;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(1500);
	localparam logic [PRICE_W-1:0]  PRICE_MAX    = {PRICE_W{1'b1}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} wpbd_state_t;

	typedef struct packed {
		logic start;
		logic walk;
		logic finish;
	} wpbd_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic out_free;
	} wpbd_status_t;

endpackage

`default_nettype wire

// File: design/windowed_price_breakout_detector_top.sv
// Top level of the windowed price breakout detector.
`default_nettype none

// Each request carries a tick (timestamp in ms, price in half-unit steps and
// a direction). The block walks its tick ring from the newest stored entry
// toward the oldest, one ring entry per clock through the single read port
// of the ring memory, and takes the minimum and maximum price. The walk stops
// after it has included the first entry older than tick_time - window_ms
// (saturated at zero) or after the last filled entry. The range is widened
// against a tracked book floor, the breakout flag is computed, the tick is
// stored and the floor is updated. A request goes through the accepting
// cycle, the walk over the examined ring entries (each memory read is
// registered) and a finish state that waits for a free output register;
// the next request can be taken in the cycle right after the finish. The
// result sits in an output register, so the next request may be taken
// while a result still waits; a second finished request waits only if that
// register is still full. window_ms is written through cfg_we and cfg_wdata
// and resets to 1500; it should only be written while the block is idle. The
// ring needs no clearing pass after reset, since the walk never goes past the
// fill count.
module windowed_price_breakout_detector_top #(
	parameter int RING_DEPTH = wpbd_pkg::RING_DEPTH_DEFAULT
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [wpbd_pkg::WINDOW_W-1:0]   cfg_wdata,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  [wpbd_pkg::TIME_W-1:0]     tick_time,
	input  wire  [wpbd_pkg::PRICE_W-1:0]    tick_price,
	input  wire                             move_down,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic                            breakout,
	output logic [wpbd_pkg::PRICE_W-1:0]    range_low,
	output logic [wpbd_pkg::PRICE_W-1:0]    range_high
);
	import wpbd_pkg::*;

	// Command and status bundles between the sequencer and the datapath.
	wpbd_cmd_t    cmd;
	wpbd_status_t status;

	wpbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath owns the ring memories, the walk accumulators, the book
	// floor, the window register and the output register.
	wpbd_datapath #(
		.RING_DEPTH (RING_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.tick_time  (tick_time),
		.tick_price (tick_price),
		.move_down  (move_down),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.breakout   (breakout),
		.range_low  (range_low),
		.range_high (range_high)
	);

endmodule

`default_nettype wire

// File: design/wpbd_ctrl.sv
// Controller state machine that sequences the accept, walk and finish phases.
`default_nettype none

module wpbd_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wpbd_pkg::wpbd_status_t status,
	output wpbd_pkg::wpbd_cmd_t    cmd
);
	import wpbd_pkg::*;

	wpbd_state_t state_q;
	wpbd_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_nxt = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (status.walk_done) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// Hold the finished range until the output register is free.
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: design/wpbd_datapath.sv
// Datapath: tick ring memories, range walk, floor tracking and output register.
`default_nettype none

module wpbd_datapath #(
	parameter int RING_DEPTH = wpbd_pkg::RING_DEPTH_DEFAULT
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [wpbd_pkg::WINDOW_W-1:0]   cfg_wdata,
	input  wire  [wpbd_pkg::TIME_W-1:0]     tick_time,
	input  wire  [wpbd_pkg::PRICE_W-1:0]    tick_price,
	input  wire                             move_down,
	input  wpbd_pkg::wpbd_cmd_t             cmd,
	output wpbd_pkg::wpbd_status_t          status,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic                            breakout,
	output logic [wpbd_pkg::PRICE_W-1:0]    range_low,
	output logic [wpbd_pkg::PRICE_W-1:0]    range_high
);
	import wpbd_pkg::*;

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic [TIME_W-1:0]  time_ring  [RING_DEPTH];
	logic [PRICE_W-1:0] price_ring [RING_DEPTH];

	logic [WINDOW_W-1:0] window_q;
	logic [PTR_W-1:0]    wp_q;
	logic [CNT_W-1:0]    fill_q;
	logic [PRICE_W-1:0]  floor_q;
	logic [CNT_W-1:0]    rem_q;
	logic                out_valid_q;

	logic [TIME_W-1:0]   cutoff_q;
	logic [PRICE_W-1:0]  price_q;
	logic                down_q;
	logic [TIME_W-1:0]   now_q;
	logic [PRICE_W-1:0]  lo_q;
	logic [PRICE_W-1:0]  hi_q;
	logic [PTR_W-1:0]    rd_idx_q;

	logic                rd_vld_s1;
	logic                last_s1;
	logic [TIME_W-1:0]   rd_time_s1;
	logic [PRICE_W-1:0]  rd_price_s1;

	logic                breakout_q;
	logic [PRICE_W-1:0]  range_low_q;
	logic [PRICE_W-1:0]  range_high_q;

	logic                issue;
	logic [PTR_W-1:0]    wp_prev;
	logic [PTR_W-1:0]    rd_idx_prev;
	logic [TIME_W-1:0]   window_ext;
	logic [PRICE_W-1:0]  floor_inc;
	logic [PRICE_W-1:0]  lo_w;
	logic [PRICE_W-1:0]  hi_w;
	logic                brk_w;
	logic [PRICE_W-1:0]  floor_nxt;

	assign issue       = cmd.walk && (rem_q != '0);
	assign wp_prev     = (wp_q == '0) ? PTR_LAST : wp_q - PTR_W'(1);
	assign rd_idx_prev = (rd_idx_q == '0) ? PTR_LAST : rd_idx_q - PTR_W'(1);
	assign window_ext  = TIME_W'(window_q);

	// The walk ends on an entry older than the cutoff, on the last filled
	// entry, or at once when the ring is empty.
	assign status.walk_done = (rd_vld_s1 && ((rd_time_s1 < cutoff_q) || last_s1))
		|| (!rd_vld_s1 && (rem_q == '0));
	assign status.out_free  = !out_valid_q || out_ready;

	always_comb begin
		floor_inc = floor_q + PRICE_W'(1);
		lo_w      = lo_q;
		hi_w      = hi_q;
		if (hi_q < floor_inc) begin
			hi_w = floor_inc;
		end else if (lo_q > floor_q) begin
			lo_w = floor_q;
		end
		brk_w = down_q ? (price_q > hi_w) : (price_q < lo_w);
		if (price_q > floor_inc) begin
			floor_nxt = price_q - PRICE_W'(1);
		end else if (price_q < floor_q) begin
			floor_nxt = price_q;
		end else begin
			floor_nxt = floor_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RESET;
			wp_q        <= '0;
			fill_q      <= '0;
			floor_q     <= '0;
			rem_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			if (cmd.start) begin
				rem_q     <= fill_q;
				rd_vld_s1 <= 1'b0;
			end else begin
				rd_vld_s1 <= issue;
				if (issue) begin
					rem_q <= rem_q - CNT_ONE;
				end
			end
			if (cmd.finish) begin
				wp_q    <= (wp_q == PTR_LAST) ? '0 : wp_q + PTR_W'(1);
				floor_q <= floor_nxt;
				if (fill_q != CNT_FULL) begin
					fill_q <= fill_q + CNT_ONE;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			now_q    <= tick_time;
			price_q  <= tick_price;
			down_q   <= move_down;
			cutoff_q <= (tick_time >= window_ext) ? tick_time - window_ext : '0;
			lo_q     <= PRICE_MAX;
			hi_q     <= '0;
			rd_idx_q <= wp_prev;
		end else begin
			if (issue) begin
				rd_idx_q <= rd_idx_prev;
				last_s1  <= (rem_q == CNT_ONE);
			end
			if (cmd.walk && rd_vld_s1) begin
				if (rd_price_s1 < lo_q) begin
					lo_q <= rd_price_s1;
				end
				if (rd_price_s1 > hi_q) begin
					hi_q <= rd_price_s1;
				end
			end
		end
		if (cmd.finish) begin
			breakout_q   <= brk_w;
			range_low_q  <= lo_w;
			range_high_q <= hi_w;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_time_s1  <= time_ring[rd_idx_q];
			rd_price_s1 <= price_ring[rd_idx_q];
		end
		if (cmd.finish) begin
			time_ring[wp_q]  <= now_q;
			price_ring[wp_q] <= price_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign breakout   = breakout_q;
	assign range_low  = range_low_q;
	assign range_high = range_high_q;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_FULL)
		else $error("fill count exceeds ring depth");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= fill_q)
		else $error("walk has more entries left than the ring holds");

	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished request did not reach the output register");

	a_floor_room: assert property (@(posedge clk) disable iff (!arst_n)
		floor_q != PRICE_MAX)
		else $error("book floor leaves no room for the upper bound");
`endif

endmodule

`default_nettype wire
